// ----- rtl/core/hapd_pkg.sv -----
// ----------------------------------------------------------------------------
// hapd_pkg
// Shared constants, types and tables of the harmonic amplitude/phase DFT.
// ----------------------------------------------------------------------------
`default_nettype none

package hapd_pkg;

  localparam int unsigned POINTS      = 80;
  localparam int unsigned IDX_W       = $clog2(POINTS);
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned ACC_BITS    = 40;
  localparam int unsigned BIN_W       = 6;
  localparam int unsigned PROD_W      = 2 * SAMPLE_BITS;
  localparam int unsigned QUARTER     = POINTS / 4;
  localparam logic [BIN_W-1:0] NB_MAX   = BIN_W'(POINTS / 2 + 1);
  localparam logic [BIN_W-1:0] NB_RESET = 6'd22;
  localparam logic [14:0] HALF_PI_Q13   = 15'd12868;
  localparam logic [31:0] RAD_PER_ANGLE = 32'd3373259426;
  localparam int unsigned CORDIC_STEPS  = 30;
  localparam int unsigned ROOT_STEPS    = ACC_BITS;
  // divide by ten as multiply by ceil(2^27/10), exact for 24-bit dividends
  localparam int unsigned QUO_W         = 21;
  localparam logic [23:0] RECIP_TEN     = 24'd13421773;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] c;
    logic signed [SAMPLE_BITS-1:0] s;
  } twiddle_t;

  // accumulator status handed from the mac to the post stage
  typedef struct packed {
    logic                       done;
    logic signed [ACC_BITS-1:0] re;
    logic signed [ACC_BITS-1:0] im;
  } acc_t;

  typedef struct packed {
    logic        done;
    logic [15:0] amplitude;
    logic [14:0] phase;
  } post_res_t;

  // q15 cosine of 4.5 degree steps over one quadrant
  function automatic logic [15:0] cos_q15(input logic [4:0] j);
    logic [15:0] v;
    case (j)
      5'd0:  v = 16'd32767;
      5'd1:  v = 16'd32667;
      5'd2:  v = 16'd32365;
      5'd3:  v = 16'd31863;
      5'd4:  v = 16'd31164;
      5'd5:  v = 16'd30274;
      5'd6:  v = 16'd29197;
      5'd7:  v = 16'd27939;
      5'd8:  v = 16'd26510;
      5'd9:  v = 16'd24917;
      5'd10: v = 16'd23170;
      5'd11: v = 16'd21281;
      5'd12: v = 16'd19261;
      5'd13: v = 16'd17121;
      5'd14: v = 16'd14876;
      5'd15: v = 16'd12540;
      5'd16: v = 16'd10126;
      5'd17: v = 16'd7650;
      5'd18: v = 16'd5126;
      5'd19: v = 16'd2571;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic twiddle_t twiddle(input logic [IDX_W-1:0] m);
    logic [1:0]                    q;
    logic [4:0]                    j;
    logic signed [SAMPLE_BITS-1:0] cr;
    logic signed [SAMPLE_BITS-1:0] sr;
    twiddle_t                      t;
    if (m >= IDX_W'(3 * QUARTER)) begin
      q = 2'd3;
      j = 5'(m - IDX_W'(3 * QUARTER));
    end else if (m >= IDX_W'(2 * QUARTER)) begin
      q = 2'd2;
      j = 5'(m - IDX_W'(2 * QUARTER));
    end else if (m >= IDX_W'(QUARTER)) begin
      q = 2'd1;
      j = 5'(m - IDX_W'(QUARTER));
    end else begin
      q = 2'd0;
      j = 5'(m);
    end
    cr = signed'(cos_q15(j));
    sr = signed'(cos_q15(5'(5'(QUARTER) - j)));
    case (q)
      2'd0: begin t.c = cr;  t.s = sr;  end
      2'd1: begin t.c = -sr; t.s = cr;  end
      2'd2: begin t.c = -cr; t.s = -sr; end
      default: begin t.c = sr; t.s = -cr; end
    endcase
    return t;
  endfunction

  function automatic logic [29:0] cordic_angle(input logic [4:0] i);
    logic [29:0] a;
    case (i)
      5'd0:  a = 30'd536870912;
      5'd1:  a = 30'd316933406;
      5'd2:  a = 30'd167458907;
      5'd3:  a = 30'd85004756;
      5'd4:  a = 30'd42667331;
      5'd5:  a = 30'd21354465;
      5'd6:  a = 30'd10679838;
      5'd7:  a = 30'd5340245;
      5'd8:  a = 30'd2670163;
      5'd9:  a = 30'd1335087;
      5'd10: a = 30'd667544;
      5'd11: a = 30'd333772;
      5'd12: a = 30'd166886;
      5'd13: a = 30'd83443;
      5'd14: a = 30'd41722;
      5'd15: a = 30'd20861;
      5'd16: a = 30'd10430;
      5'd17: a = 30'd5215;
      5'd18: a = 30'd2608;
      5'd19: a = 30'd1304;
      5'd20: a = 30'd652;
      5'd21: a = 30'd326;
      5'd22: a = 30'd163;
      5'd23: a = 30'd81;
      5'd24: a = 30'd41;
      5'd25: a = 30'd20;
      5'd26: a = 30'd10;
      5'd27: a = 30'd5;
      5'd28: a = 30'd3;
      5'd29: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/hapd_ram.sv -----
// ----------------------------------------------------------------------------
// hapd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hapd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 80
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hapd_mac.sv -----
// ----------------------------------------------------------------------------
// hapd_mac
// Frame buffer and pipelined complex multiply-accumulate for one DFT bin.
// ----------------------------------------------------------------------------
`default_nettype none

module hapd_mac (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                wr_en_i,
  input  wire logic [hapd_pkg::IDX_W-1:0]          wr_addr_i,
  input  wire logic [hapd_pkg::SAMPLE_BITS-1:0]    wr_data_i,
  input  wire logic                                start_i,
  input  wire logic [hapd_pkg::BIN_W-1:0]          k_i,
  output      hapd_pkg::acc_t                      acc_o
);
  import hapd_pkg::*;

  logic                          run_q;
  logic [IDX_W-1:0]              n_q;
  logic [IDX_W-1:0]              m_q;
  logic [IDX_W-1:0]              m_d;
  logic [IDX_W:0]                m_sum;
  logic [BIN_W-1:0]              k_q;
  logic                          v1_q, v2_q, v3_q;
  logic                          last1_q, last2_q, last3_q;
  logic [IDX_W-1:0]              m1_q;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] x2_q;
  twiddle_t                      tw2_q;
  logic signed [PROD_W-1:0]      pre_q;
  logic signed [PROD_W-1:0]      pim_q;
  logic signed [ACC_BITS-1:0]    re_q;
  logic signed [ACC_BITS-1:0]    im_q;
  logic                          done_q;

  hapd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (POINTS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en_i),
    .waddr_i (wr_addr_i),
    .wdata_i (wr_data_i),
    .re_i    (run_q),
    .raddr_i (n_q),
    .rdata_o (rdata)
  );

  // twiddle index k*n mod POINTS, stepped by k
  always_comb begin
    m_sum = {1'b0, m_q} + (IDX_W + 1)'(k_q);
    if (m_sum >= (IDX_W + 1)'(POINTS)) begin
      m_sum = m_sum - (IDX_W + 1)'(POINTS);
    end
    m_d = m_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      done_q  <= 1'b0;
      n_q     <= '0;
      m_q     <= '0;
      k_q     <= '0;
      last1_q <= 1'b0;
      last2_q <= 1'b0;
      last3_q <= 1'b0;
    end else begin
      v1_q    <= run_q;
      last1_q <= run_q && (n_q == IDX_W'(POINTS - 1));
      v2_q    <= v1_q;
      last2_q <= last1_q;
      v3_q    <= v2_q;
      last3_q <= last2_q;
      done_q  <= v3_q && last3_q;
      if (start_i) begin
        run_q <= 1'b1;
        n_q   <= '0;
        m_q   <= '0;
        k_q   <= k_i;
      end else if (run_q) begin
        m_q <= m_d;
        n_q <= n_q + IDX_W'(1);
        if (n_q == IDX_W'(POINTS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q  <= m_q;
    x2_q  <= signed'(rdata);
    tw2_q <= twiddle(m1_q);
    pre_q <= x2_q * tw2_q.c;
    pim_q <= x2_q * tw2_q.s;
    if (start_i) begin
      re_q <= '0;
      im_q <= '0;
    end else if (v3_q) begin
      re_q <= re_q + ACC_BITS'(pre_q);
      im_q <= im_q - ACC_BITS'(pim_q);
    end
  end

  assign acc_o.done = done_q;
  assign acc_o.re   = re_q;
  assign acc_o.im   = im_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q && !v1_q && !v2_q && !v3_q)
    else $error("mac started while busy");
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(last3_q))
    else $error("mac done without last product");
  a_run_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && !start_i && n_q == IDX_W'(POINTS - 1)) |=> !run_q)
    else $error("mac ran past frame end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hapd_post.sv -----
// ----------------------------------------------------------------------------
// hapd_post
// Magnitude (serial squares, square root, divide) and CORDIC phase of a bin.
// ----------------------------------------------------------------------------
`default_nettype none

module hapd_post (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire hapd_pkg::acc_t                       acc_i,
  output      hapd_pkg::post_res_t                  res_o
);
  import hapd_pkg::*;

  typedef enum logic [4:0] {
    P_IDLE = 5'b00001,
    P_SQ   = 5'b00010,
    P_ROOT = 5'b00100,
    P_DIV  = 5'b01000,
    P_FIN  = 5'b10000
  } post_state_e;

  localparam int unsigned HALF_W = ACC_BITS / 2;
  localparam int unsigned SUM_W  = 2 * ACC_BITS;
  localparam int unsigned REM_W  = ACC_BITS + 3;
  localparam int unsigned XY_W   = ACC_BITS + 2;

  post_state_e              state_q;
  logic [5:0]               step_q;
  logic [ACC_BITS-1:0]      mre_q, mim_q;
  logic [2*HALF_W-1:0]      prod_q;
  logic [1:0]               psh_q;
  logic                     pval_q;
  logic [SUM_W-1:0]         sum_q;
  logic [SUM_W-1:0]         sum_add;
  logic [REM_W-1:0]         rem_q, rem_n, trial;
  logic [ACC_BITS-1:0]      root_q;
  logic signed [XY_W-1:0]   x_q, y_q, dx, dy;
  logic signed [31:0]       z_q;
  logic [30:0]              zc;
  logic [62:0]              pm_q;
  logic                     neg_q, re_zero_q, im_zero_q, im_neg_q;
  logic [47:0]              quo_prod;
  logic [QUO_W-1:0]         quo_q;
  logic [HALF_W-1:0]        ma, mb;
  logic [QUO_W:0]           qa;
  logic [63:0]              pr;
  logic [15:0]              pmag;
  logic [15:0]              amp_q;
  logic [14:0]              ph_q;
  logic                     done_q;
  logic [ACC_BITS-1:0]      abs_re, abs_im;

  assign abs_re = acc_i.re[ACC_BITS-1] ? ACC_BITS'(-acc_i.re) : acc_i.re;
  assign abs_im = acc_i.im[ACC_BITS-1] ? ACC_BITS'(-acc_i.im) : acc_i.im;

  // partial product operands: high*high, high*low, low*low of |re| then |im|
  always_comb begin
    ma = mre_q[ACC_BITS-1:HALF_W];
    mb = mre_q[ACC_BITS-1:HALF_W];
    case (step_q)
      6'd0: begin ma = mre_q[ACC_BITS-1:HALF_W]; mb = mre_q[ACC_BITS-1:HALF_W]; end
      6'd1: begin ma = mre_q[ACC_BITS-1:HALF_W]; mb = mre_q[HALF_W-1:0]; end
      6'd2: begin ma = mre_q[HALF_W-1:0]; mb = mre_q[HALF_W-1:0]; end
      6'd3: begin ma = mim_q[ACC_BITS-1:HALF_W]; mb = mim_q[ACC_BITS-1:HALF_W]; end
      6'd4: begin ma = mim_q[ACC_BITS-1:HALF_W]; mb = mim_q[HALF_W-1:0]; end
      default: begin ma = mim_q[HALF_W-1:0]; mb = mim_q[HALF_W-1:0]; end
    endcase
  end

  always_comb begin
    case (psh_q)
      2'd0:    sum_add = SUM_W'(prod_q) << (2 * HALF_W);
      2'd1:    sum_add = SUM_W'(prod_q) << (HALF_W + 1);
      default: sum_add = SUM_W'(prod_q);
    endcase
  end

  assign rem_n = {rem_q[REM_W-3:0], sum_q[SUM_W-1:SUM_W-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign dx    = y_q >>> step_q[4:0];
  assign dy    = x_q >>> step_q[4:0];

  // amplitude rounding: root / (10 * 2^16), then +1 and halve
  assign quo_prod = root_q[ACC_BITS-1:ACC_BITS-24] * RECIP_TEN;

  always_comb begin
    if (z_q < 0) begin
      zc = '0;
    end else if (z_q > 32'sd1073741824) begin
      zc = 31'd1073741824;
    end else begin
      zc = z_q[30:0];
    end
  end

  assign qa = {1'b0, quo_q} + (QUO_W + 1)'(1);
  assign pr = {1'b0, pm_q} + 64'h0000_8000_0000_0000;
  assign pmag = (pr[63:48] > {1'b0, HALF_PI_Q13}) ? {1'b0, HALF_PI_Q13} : pr[63:48];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_IDLE;
      step_q  <= '0;
      pval_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        P_IDLE: begin
          if (acc_i.done) begin
            state_q <= P_SQ;
            step_q  <= '0;
          end
        end
        P_SQ: begin
          pval_q <= (step_q < 6'd6);
          if (step_q == 6'd6) begin
            state_q <= P_ROOT;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        P_ROOT: begin
          pval_q <= 1'b0;
          if (step_q == 6'(ROOT_STEPS - 1)) begin
            state_q <= P_DIV;
            step_q  <= '0;
          end else begin
            step_q <= step_q + 6'd1;
          end
        end
        P_DIV: begin
          state_q <= P_FIN;
          step_q  <= '0;
        end
        P_FIN: begin
          done_q  <= 1'b1;
          state_q <= P_IDLE;
        end
        default: state_q <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        mre_q     <= abs_re;
        mim_q     <= abs_im;
        sum_q     <= '0;
        x_q       <= XY_W'(abs_re);
        y_q       <= XY_W'(abs_im);
        z_q       <= '0;
        neg_q     <= acc_i.re[ACC_BITS-1] ^ acc_i.im[ACC_BITS-1];
        re_zero_q <= (acc_i.re == '0);
        im_zero_q <= (acc_i.im == '0);
        im_neg_q  <= acc_i.im[ACC_BITS-1];
      end
      P_SQ: begin
        prod_q <= ma * mb;
        case (step_q)
          6'd0, 6'd3: psh_q <= 2'd0;
          6'd1, 6'd4: psh_q <= 2'd1;
          default:    psh_q <= 2'd2;
        endcase
        if (pval_q) begin
          sum_q <= sum_q + sum_add;
        end
        rem_q  <= '0;
        root_q <= '0;
      end
      P_ROOT: begin
        sum_q <= sum_q << 2;
        if (rem_n >= trial) begin
          rem_q  <= rem_n - trial;
          root_q <= {root_q[ACC_BITS-2:0], 1'b1};
        end else begin
          rem_q  <= rem_n;
          root_q <= {root_q[ACC_BITS-2:0], 1'b0};
        end
        if (step_q < 6'(CORDIC_STEPS)) begin
          if (y_q >= 0) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + signed'({2'b00, cordic_angle(step_q[4:0])});
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - signed'({2'b00, cordic_angle(step_q[4:0])});
          end
        end
      end
      P_DIV: begin
        pm_q  <= zc * RAD_PER_ANGLE;
        quo_q <= quo_prod[47:27];
      end
      P_FIN: begin
        amp_q <= (qa[QUO_W:1] > QUO_W'(16'hFFFF)) ? 16'hFFFF : qa[16:1];
        if (re_zero_q) begin
          if (im_zero_q) begin
            ph_q <= '0;
          end else begin
            ph_q <= im_neg_q ? 15'(-HALF_PI_Q13) : HALF_PI_Q13;
          end
        end else if (im_zero_q) begin
          ph_q <= '0;
        end else begin
          ph_q <= neg_q ? 15'(-pmag) : pmag[14:0];
        end
      end
      default: ;
    endcase
  end

  assign res_o.done      = done_q;
  assign res_o.amplitude = amp_q;
  assign res_o.phase     = ph_q;

`ifndef SYNTHESIS
  a_start_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_i.done |-> state_q == P_IDLE)
    else $error("post stage started while busy");
  a_done_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == P_FIN)
    else $error("post result without final step");
  a_root_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == P_ROOT && step_q == 6'(ROOT_STEPS - 1)) |=> state_q == P_DIV)
    else $error("square root sequence length wrong");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/harmonic_amplitude_phase_dft_top.sv -----
// ----------------------------------------------------------------------------
// harmonic_amplitude_phase_dft_top
// 80-point DFT harmonic amplitude and phase analyzer.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a frame fills; after the 80th sample
// the block stops taking samples and works through bins 0 to bins_reported-1
// one at a time. Each bin passes through the multiply-accumulate (one frame
// buffer read per sample through a single RAM read port) and then the
// magnitude and phase unit (partial-product squares, a 40-step square root
// overlapped with a 30-step CORDIC, a reciprocal divide by ten, a rounding
// step and the hand-off). A stalled result holds the next bin until it is
// taken. The frame buffer needs no clearing after reset. bins_reported is
// sampled at the end of each frame, zero counts as one and values above 41
// count as 41.
`default_nettype none

module harmonic_amplitude_phase_dft_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   sample_valid_i,
  output      logic                                   sample_ready_o,
  input  wire logic signed [hapd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  wire logic                                   cfg_valid_i,
  output      logic                                   cfg_ready_o,
  input  wire logic [hapd_pkg::BIN_W-1:0]             bins_reported_i,
  output      logic                                   result_valid_o,
  input  wire logic                                   result_ready_i,
  output      logic [hapd_pkg::BIN_W-1:0]             bin_index_o,
  output      logic [15:0]                            amplitude_o,
  output      logic signed [14:0]                     phase_o,
  output      logic                                   last_bin_o
);
  import hapd_pkg::*;

  typedef enum logic [2:0] {
    T_FILL = 3'b001,
    T_MAC  = 3'b010,
    T_POST = 3'b100
  } top_state_e;

  top_state_e       state_q;
  logic [IDX_W-1:0] cnt_q;
  logic [BIN_W-1:0] bin_q;
  logic [BIN_W-1:0] nb_q;
  logic [BIN_W-1:0] nb_clamped;
  logic [BIN_W-1:0] cfg_q;
  logic             pend_q;
  logic             in_acc;
  logic             frame_full;
  logic             mac_start;
  logic             out_load;
  logic             is_last;
  logic             out_valid_q;
  acc_t             acc;
  post_res_t        res;

  assign sample_ready_o = (state_q == T_FILL);
  assign cfg_ready_o    = 1'b1;
  assign in_acc         = sample_valid_i && sample_ready_o;
  assign frame_full     = in_acc && (cnt_q == IDX_W'(POINTS - 1));
  assign is_last        = (bin_q == nb_q - BIN_W'(1));
  assign out_load       = (state_q == T_POST) && pend_q && (!out_valid_q || result_ready_i);
  assign mac_start      = frame_full || (out_load && !is_last);

  always_comb begin
    if (cfg_q == '0) begin
      nb_clamped = BIN_W'(1);
    end else if (cfg_q > NB_MAX) begin
      nb_clamped = NB_MAX;
    end else begin
      nb_clamped = cfg_q;
    end
  end

  hapd_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_addr_i (cnt_q),
    .wr_data_i (sample_i),
    .start_i   (mac_start),
    .k_i       (frame_full ? '0 : bin_q + BIN_W'(1)),
    .acc_o     (acc)
  );

  hapd_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_FILL;
      cnt_q       <= '0;
      bin_q       <= '0;
      nb_q        <= NB_RESET;
      cfg_q       <= NB_RESET;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        cfg_q <= bins_reported_i;
      end
      if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (res.done) begin
        pend_q <= 1'b1;
      end
      unique case (state_q)
        T_FILL: begin
          if (in_acc) begin
            if (frame_full) begin
              cnt_q   <= '0;
              bin_q   <= '0;
              nb_q    <= nb_clamped;
              state_q <= T_MAC;
            end else begin
              cnt_q <= cnt_q + IDX_W'(1);
            end
          end
        end
        T_MAC: begin
          if (acc.done) begin
            state_q <= T_POST;
          end
        end
        T_POST: begin
          if (out_load) begin
            pend_q      <= 1'b0;
            out_valid_q <= 1'b1;
            if (is_last) begin
              state_q <= T_FILL;
            end else begin
              bin_q   <= bin_q + BIN_W'(1);
              state_q <= T_MAC;
            end
          end
        end
        default: state_q <= T_FILL;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      bin_index_o <= bin_q;
      amplitude_o <= res.amplitude;
      phase_o     <= signed'(res.phase);
      last_bin_o  <= is_last;
    end
  end

  assign result_valid_o = out_valid_q;

`ifndef SYNTHESIS
  a_mac_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc.done |-> state_q == T_MAC)
    else $error("accumulation finished outside bin computation");
  a_post_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.done |-> state_q == T_POST)
    else $error("bin result outside post state");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IDX_W'(POINTS - 1))
    else $error("sample count out of range");
  a_last_to_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && is_last) |=> state_q == T_FILL)
    else $error("frame did not restart after last bin");
`endif

endmodule

`default_nettype wire
